[design/ufd_pkg.sv]
// Shared types, constants and decode functions for the forgiving UTF-8 decoder.
package ufd_pkg;

  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [7:0]  CONT_TAG    = 8'h80;
  localparam logic [7:0]  LEAD_MASK   = 8'hF8;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] PRIV_LO     = 21'h00EF80;
  localparam logic [20:0] PRIV_HI     = 21'h00EFFF;
  localparam logic [20:0] ESCAPE_BASE = 21'h00EF00;

  localparam logic [1:0] MODE_LENGTH = 2'd0;
  localparam logic [1:0] MODE_LATIN1 = 2'd1;
  localparam logic [1:0] MODE_ESCAPE = 2'd2;
  localparam logic [1:0] MODE_STRICT = 2'd3;

  // One classified byte: raw value, sequence length it opens, continuation flag.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] need;
    logic       cont;
  } ufd_byte_t;

  // Queue entry between front and back.
  typedef struct packed {
    ufd_byte_t b;
    logic      eot;
  } ufd_item_t;

  typedef ufd_byte_t [3:0] ufd_buf_t;

  typedef struct packed {
    logic        decided;
    logic [20:0] cp;
    logic [2:0]  len;
    logic        fb;
  } ufd_scan_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } ufd_q_status_t;

  typedef struct packed {
    logic       busy;
    logic       eot;
    logic [2:0] count;
  } ufd_back_status_t;

  function automatic ufd_byte_t classify(input logic [7:0] c);
    ufd_byte_t r;
    r.data = c;
    r.cont = ((c & CONT_MASK) == CONT_TAG);
    unique case (c & LEAD_MASK)
      8'hC0, 8'hC8, 8'hD0, 8'hD8: r.need = 3'd2;
      8'hE0, 8'hE8:               r.need = 3'd3;
      8'hF0:                      r.need = 3'd4;
      default:                    r.need = 3'd1;
    endcase
    return r;
  endfunction

  // Decide one character at the head of the buffer, or report that it must wait.
  function automatic ufd_scan_t scan(input ufd_buf_t b, input logic [2:0] avail,
                                     input logic eot, input logic [1:0] mode);
    ufd_scan_t   r;
    logic [7:0]  c;
    logic [2:0]  need;
    logic        alone;
    logic        hold;
    logic        done;
    logic [20:0] v;
    c     = b[0].data;
    need  = b[0].need;
    alone = (need == 3'd1);
    done  = alone;
    hold  = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (!done && 3'(i) < need) begin
        if (3'(i) >= avail) begin
          if (eot) alone = 1'b1;
          else     hold  = 1'b1;
          done = 1'b1;
        end else if (!b[i].cont) begin
          alone = 1'b1;
          done  = 1'b1;
        end
      end
    end
    case (need)
      3'd2:    v = {10'd0, c[4:0], b[1].data[5:0]};
      3'd3:    v = {5'd0, c[3:0], b[1].data[5:0], b[2].data[5:0]};
      default: v = {c[2:0], b[1].data[5:0], b[2].data[5:0], b[3].data[5:0]};
    endcase
    if (!alone && need >= 3'd3) begin
      if (mode >= MODE_ESCAPE && v >= SURR_LO && v <= SURR_HI) alone = 1'b1;
      if (mode == MODE_STRICT && v >= PRIV_LO && v <= PRIV_HI) alone = 1'b1;
    end
    r.decided = !hold;
    if (alone) begin
      if (mode == MODE_LENGTH)                r.cp = '0;
      else if (mode >= MODE_ESCAPE && c[7])   r.cp = ESCAPE_BASE + 21'(c);
      else                                    r.cp = 21'(c);
      r.len = 3'd1;
      r.fb  = c[7];
    end else begin
      r.cp  = (mode == MODE_LENGTH) ? '0 : v;
      r.len = need;
      r.fb  = 1'b0;
    end
    return r;
  endfunction

endpackage

[design/ufd_front.sv]
// Input stage: takes bytes, classifies them and pushes them into the queue.
module ufd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_text,
  input  ufd_pkg::ufd_q_status_t q_status,
  output logic                   push_valid,
  output ufd_pkg::ufd_item_t     push_item
);

  logic               held;
  ufd_pkg::ufd_item_t item;

  // holding register only stalls when the queue is full
  assign in_stall   = held && q_status.full;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.b   <= ufd_pkg::classify(data_byte);
      item.eot <= end_of_text;
    end
  end

endmodule

[design/ufd_queue.sv]
// Two-entry queue between the classifying front and the decoding back.
module ufd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  input  ufd_pkg::ufd_item_t     push_item,
  input  logic                   pop_ready,
  output ufd_pkg::ufd_item_t     pop_item,
  output ufd_pkg::ufd_q_status_t status
);

  ufd_pkg::ufd_item_t slots [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         fill;
  logic               push;
  logic               pop;

  assign status.full      = (fill == 2'd2);
  assign status.not_empty = (fill != 2'd0);
  assign push             = push_valid && !status.full;
  assign pop              = pop_ready && status.not_empty;
  assign pop_item         = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_item;
  end

endmodule

[design/ufd_back.sv]
// Decode engine: holds pending bytes and emits one character per cycle while busy and not stalled.
module ufd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                mode,
  input  ufd_pkg::ufd_q_status_t    q_status,
  input  ufd_pkg::ufd_item_t        pop_item,
  output logic                      pop_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [20:0]               code_point,
  output logic [2:0]                seq_length,
  output logic                      fell_back,
  output logic                      last_of_run,
  output ufd_pkg::ufd_back_status_t status
);

  ufd_pkg::ufd_buf_t buffer;
  ufd_pkg::ufd_buf_t shifted;
  logic [2:0]        count;
  logic              eot;
  logic              busy;
  ufd_pkg::ufd_scan_t cur;
  ufd_pkg::ufd_scan_t nxt;
  logic [2:0]        rem;
  logic [2:0]        sidx;
  logic              out_free;
  logic              emit;
  logic              last;
  logic              load;

  assign cur = ufd_pkg::scan(buffer, count, eot, mode);

  always_comb begin
    sidx = '0;
    for (int i = 0; i < 4; i++) begin
      sidx       = 3'(i) + cur.len;
      shifted[i] = buffer[sidx[1:0]];
    end
  end

  assign rem      = count - cur.len;
  // look one character ahead to flag the last result of this byte
  assign nxt      = ufd_pkg::scan(shifted, rem, eot, mode);
  assign last     = (rem == 3'd0) || !nxt.decided;
  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && cur.decided && out_free;
  assign pop_ready = !busy;
  assign load     = !busy && q_status.not_empty;

  assign status.busy  = busy;
  assign status.eot   = eot;
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= 3'd0;
      eot       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= emit;
      if (busy) begin
        if (!cur.decided) begin
          busy <= 1'b0;
        end else if (out_free) begin
          count <= rem;
          if (last) busy <= 1'b0;
        end
      end else if (load) begin
        count <= count + 3'd1;
        eot   <= pop_item.eot;
        busy  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_point  <= cur.cp;
      seq_length  <= cur.len;
      fell_back   <= cur.fb;
      last_of_run <= last;
      buffer      <= shifted;
    end
    if (load) buffer[count[1:0]] <= pop_item.b;
  end

endmodule

[design/forgiving_utf8_decoder.sv]
// Top level of the forgiving UTF-8 decoder: front, queue, back and mode register.
//
// Bytes enter through a holding register, are classified (lead length,
// continuation flag) and wait in a two-entry queue. The back end pulls one
// byte at a time, appends it to up to three pending bytes and then emits the
// decoded characters one per cycle, while the output is not stalled, through
// an output register. Each byte is loaded first and its results (one to
// four) then go out in turn; the next byte is loaded only after the last
// result of the current one. A byte that only extends an open sequence is
// loaded and then scanned, finds the sequence still open and gives no result.
// Bad continuations and end of text make the lead byte go out alone and the
// rest is rescanned. last_of_run marks the final result caused by a byte.
// decode_mode (reset 1) is written through cfg_we/cfg_data and must only
// change while the decoder is idle. Pending bytes hold no reset value; the
// fill count clears on rst, so nothing stale is ever read.
module forgiving_utf8_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [2:0]  seq_length,
  output logic        fell_back,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);

  logic [1:0]                decode_mode;
  ufd_pkg::ufd_q_status_t    q_status;
  ufd_pkg::ufd_item_t        push_item;
  ufd_pkg::ufd_item_t        pop_item;
  ufd_pkg::ufd_back_status_t back_status;
  logic                      push_valid;
  logic                      pop_ready;

  // mode register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= ufd_pkg::MODE_LATIN1;
    end else if (cfg_we) begin
      decode_mode <= cfg_data;
    end
  end

  ufd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_text(end_of_text),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  ufd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_item (push_item),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  ufd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (decode_mode),
    .q_status   (q_status),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .seq_length (seq_length),
    .fell_back  (fell_back),
    .last_of_run(last_of_run),
    .status     (back_status)
  );

  // the engine never works on an empty buffer
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    back_status.busy |-> back_status.count != 3'd0)
    else $error("decode engine busy with empty buffer");

  // at most a lead byte plus three more bytes are ever held
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.count <= 3'd4)
    else $error("pending count out of range");

  // between bytes, at most three bytes wait for completion
  a_idle_pending: assert property (@(posedge clk) disable iff (rst)
    !back_status.busy |-> back_status.count <= 3'd3)
    else $error("idle with a full buffer");

  // after end of text the buffer is flushed
  a_eot_flushed: assert property (@(posedge clk) disable iff (rst)
    (!back_status.busy && back_status.eot) |-> back_status.count == 3'd0)
    else $error("bytes left over after end of text");

endmodule

[tb/sv/forgiving_utf8_decoder_tb.sv]
// Self-checking testbench for the forgiving UTF-8 decoder: directed and random byte streams.
module forgiving_utf8_decoder_tb;

  // Watchdog bound, far above the slowest legal run (gaps, stalls, four results a byte).
  localparam int CYCLE_LIMIT   = 200000;
  // Quiet cycles after the last result, for bytes that only extend a sequence.
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PHASE_BYTES   = 10;

  // One request on the byte channel.
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_req_t;

  // One decoded character as the result channel shows it.
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_length;
    logic        fell_back;
    logic        last_of_run;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] code_point;
  logic [2:0]  seq_length;
  logic        fell_back;
  logic        last_of_run;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_data = ufd_pkg::MODE_LATIN1;

  forgiving_utf8_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .seq_length  (seq_length),
    .fell_back   (fell_back),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  text_req_t req_q[$];     // requests not yet presented
  char_t     char_q[$];    // characters predicted, not yet seen
  text_req_t next_req;
  int        bytes_left = 0;   // requests queued but not yet accepted
  int        sent_total = 0;
  int        fail_count = 0;

  // Predictor state: bytes of an open sequence and the mode in force.
  logic [2:0][7:0] held;
  int              held_cnt = 0;
  logic [1:0]      mode_q = ufd_pkg::MODE_LATIN1;

  int gap_left   = 0;
  int stall_left = 0;
  int in_calm    = 0;
  int out_calm   = 0;

  // Pause length: mostly none, some short, a few long; now and then a calm run.
  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Decide the character at the head of win. Returns 0 when it still needs
  // bytes that have not arrived yet.
  function automatic logic judge_char(input logic [3:0][7:0] win, input int avail,
                                      input logic eot, input logic [1:0] mode,
                                      output logic [20:0] cp, output logic [2:0] len,
                                      output logic fb);
    logic [7:0]  lead;
    int          need;
    int          i;
    logic        alone;
    logic [20:0] v;
    lead = win[0];
    case (lead & ufd_pkg::LEAD_MASK)
      8'hC0, 8'hC8, 8'hD0, 8'hD8: need = 2;
      8'hE0, 8'hE8:               need = 3;
      8'hF0:                      need = 4;
      default:                    need = 1;
    endcase
    alone = (need == 1);
    for (i = 1; i < 4; i++) begin
      if (!alone && i < need) begin
        if (i >= avail) begin
          if (!eot) return 1'b0;
          alone = 1'b1;    // text ends inside the sequence
        end else if ((win[i] & ufd_pkg::CONT_MASK) != ufd_pkg::CONT_TAG) begin
          alone = 1'b1;    // broken continuation
        end
      end
    end
    case (need)
      2:       v = (21'(lead & 8'h1F) << 6) | 21'(win[1] & 8'h3F);
      3:       v = (21'(lead & 8'h0F) << 12) | (21'(win[1] & 8'h3F) << 6)
                   | 21'(win[2] & 8'h3F);
      4:       v = (21'(lead & 8'h07) << 18) | (21'(win[1] & 8'h3F) << 12)
                   | (21'(win[2] & 8'h3F) << 6) | 21'(win[3] & 8'h3F);
      default: v = '0;
    endcase
    // Only the long forms are screened for surrogates and the escape range.
    if (!alone && need >= 3) begin
      if (mode >= ufd_pkg::MODE_ESCAPE && v >= ufd_pkg::SURR_LO
          && v <= ufd_pkg::SURR_HI) alone = 1'b1;
      if (mode == ufd_pkg::MODE_STRICT && v >= ufd_pkg::PRIV_LO
          && v <= ufd_pkg::PRIV_HI) alone = 1'b1;
    end
    if (alone) begin
      len = 3'd1;
      fb  = lead[7];
      if (mode == ufd_pkg::MODE_LENGTH)                 cp = '0;
      else if (mode >= ufd_pkg::MODE_ESCAPE && lead[7]) cp = ufd_pkg::ESCAPE_BASE + 21'(lead);
      else                                              cp = 21'(lead);
    end else begin
      len = 3'(need);
      fb  = 1'b0;
      cp  = (mode == ufd_pkg::MODE_LENGTH) ? '0 : v;
    end
    return 1'b1;
  endfunction

  // Append one accepted byte to the open sequence and queue every character
  // it settles; whatever stays undecided is kept for the next byte.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [3:0][7:0] pool;
    logic [3:0][7:0] win;
    char_t           found [4];
    logic [20:0]     cp;
    logic [2:0]      len;
    logic            fb;
    logic            go;
    int              n;
    int              pos;
    int              k;
    int              i;
    pool = '0;
    for (i = 0; i < held_cnt; i++) pool[i] = held[i];
    pool[held_cnt] = b;
    n   = held_cnt + 1;
    pos = 0;
    k   = 0;
    go  = 1'b1;
    while (go && pos < n && k < 4) begin
      win = pool >> (8 * pos);
      if (judge_char(win, n - pos, eot, mode_q, cp, len, fb)) begin
        found[k].code_point  = cp;
        found[k].seq_length  = len;
        found[k].fell_back   = fb;
        found[k].last_of_run = 1'b0;
        k++;
        pos += len;
      end else begin
        go = 1'b0;
      end
    end
    for (i = 0; i < k; i++) begin
      if (i == k - 1) found[i].last_of_run = 1'b1;
      char_q.insert(char_q.size(), found[i]);
    end
    held_cnt = n - pos;
    if (held_cnt > 3) held_cnt = 3;
    for (i = 0; i < held_cnt; i++) held[i] = pool[pos + i];
    bytes_left--;
  endtask

  // Driver: take the accepted request into the predictor, then present the
  // next one after its gap. A stalled request holds still.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(data_byte, end_of_text);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          next_req = req_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= next_req.data;
          end_of_text <= next_req.eot;
          gap_left = pause_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, and
  // stall the result channel at random.
  char_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $error("result with nothing predicted: code_point %0h seq_length %0d",
                 code_point, seq_length);
          fail_count++;
        end else begin
          want = char_q.pop_front();
          if (code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, code_point);
            fail_count++;
          end
          if (seq_length !== want.seq_length) begin
            $error("seq_length: expected %0d, got %0d", want.seq_length, seq_length);
            fail_count++;
          end
          if (fell_back !== want.fell_back) begin
            $error("fell_back: expected %0b, got %0b", want.fell_back, fell_back);
            fail_count++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pause_len(out_calm);
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eot);
    text_req_t r;
    r.data = b;
    r.eot  = eot;
    req_q.insert(req_q.size(), r);
    bytes_left++;
    sent_total++;
  endtask

  // Send cnt bytes of s, most significant first; eot marks the last one.
  task automatic send_seq(input logic [31:0] s, input int cnt, input logic eot);
    int i;
    for (i = cnt - 1; i >= 0; i--) send(s[8*i +: 8], eot && i == 0);
  endtask

  function automatic logic [7:0] cont_byte();
    return ufd_pkg::CONT_TAG | 8'($urandom_range(0, 63));
  endfunction

  // One random token: mostly well-formed sequences, with surrogate and
  // escape-range hits, cut-off sequences and raw noise mixed in.
  task automatic send_token();
    logic [31:0] s;
    int          cnt;
    int          r;
    int          need;
    int          m;
    int          i;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      s = 32'($urandom_range(0, 127));
      cnt = 1;
    end else if (r < 38) begin
      s = {16'd0, 8'hC0 | 8'($urandom_range(0, 31)), cont_byte()};
      cnt = 2;
    end else if (r < 58) begin
      case ($urandom_range(0, 3))
        0:       s = {8'd0, 8'hED, 8'hA0 | 8'($urandom_range(0, 31)), cont_byte()};
        1:       s = {8'd0, 8'hEE, 8'hBE | 8'($urandom_range(0, 1)), cont_byte()};
        default: s = {8'd0, 8'hE0 | 8'($urandom_range(0, 15)), cont_byte(), cont_byte()};
      endcase
      cnt = 3;
    end else if (r < 74) begin
      case ($urandom_range(0, 4))
        0:       s = {8'hF0, 8'h8D, 8'hA0 | 8'($urandom_range(0, 31)), cont_byte()};
        1:       s = {8'hF0, 8'h8E, 8'hBE | 8'($urandom_range(0, 1)), cont_byte()};
        default: s = {8'hF0 | 8'($urandom_range(0, 7)), cont_byte(), cont_byte(), cont_byte()};
      endcase
      cnt = 4;
    end else if (r < 86) begin
      // Sequence cut short by a byte that is not a continuation.
      need = $urandom_range(2, 4);
      case (need)
        2:       s = 32'(8'hC0 | 8'($urandom_range(0, 31)));
        3:       s = 32'(8'hE0 | 8'($urandom_range(0, 15)));
        default: s = 32'(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
      m = $urandom_range(0, need - 2);
      for (i = 0; i < m; i++) s = (s << 8) | 32'(cont_byte());
      if ($urandom_range(0, 1) != 0) s = (s << 8) | 32'($urandom_range(0, 127));
      else                           s = (s << 8) | 32'($urandom_range(192, 255));
      cnt = m + 2;
    end else begin
      s = 32'($urandom_range(0, 255));
      cnt = 1;
    end
    for (i = cnt - 1; i >= 0; i--) send(s[8*i +: 8], $urandom_range(0, 29) == 0);
  endtask

  // Wait until every request is taken and every prediction met, then let the
  // block settle; anything still predicted after that never came.
  task automatic settle();
    int w;
    while (bytes_left != 0) @(posedge clk);
    for (w = 0; char_q.size() != 0 && w < DRAIN_LIMIT; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (char_q.size() != 0) begin
      $error("%0d predicted characters never came out", char_q.size());
      fail_count++;
      char_q.delete();
    end
  endtask

  // Mode changes only while the decoder is idle.
  task automatic write_mode(input logic [1:0] m);
    settle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
  endtask

  logic [1:0] phase_mode [6] = '{ufd_pkg::MODE_ESCAPE, ufd_pkg::MODE_LENGTH,
                                 ufd_pkg::MODE_STRICT, ufd_pkg::MODE_LATIN1,
                                 ufd_pkg::MODE_ESCAPE, ufd_pkg::MODE_STRICT};

  initial begin
    int p;
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset mode, latin-1 fallback.
    send(8'h00, 1'b0);                     // NUL is a plain character
    send(8'h7F, 1'b0);
    send_seq(32'h00E282AC, 3, 1'b0);       // three-byte form
    send_seq(32'hF7BFBFBF, 4, 1'b0);       // highest code point
    send_seq(32'h0000C080, 2, 1'b0);       // overlong form is kept
    send_seq(32'h0000C341, 2, 1'b0);       // bad continuation: lead goes alone
    send(8'hFF, 1'b0);                     // F8-FF always stand alone
    send(8'h80, 1'b0);                     // stray continuation
    send_seq(32'h0000E282, 2, 1'b1);       // text ends inside a sequence

    write_mode(ufd_pkg::MODE_ESCAPE);
    send_seq(32'h00EDA080, 3, 1'b0);       // surrogate rejected, bytes escaped
    send_seq(32'hF09F9841, 4, 1'b0);       // four results from the last byte

    write_mode(ufd_pkg::MODE_STRICT);
    send_seq(32'h00EEBE80, 3, 1'b0);       // EF80 rejected in strict mode
    send_seq(32'h0000F09F, 2, 1'b0);       // left open across the mode change
    write_mode(ufd_pkg::MODE_LENGTH);
    send_seq(32'h00009880, 2, 1'b1);       // finished under length-only mode

    // Random phases; each ends with end of text so the buffer is flushed.
    for (p = 0; p < 6; p++) begin
      write_mode(phase_mode[p]);
      target = sent_total + PHASE_BYTES;
      while (sent_total < target) send_token();
      send(8'($urandom_range(0, 255)), 1'b1);
    end

    settle();
    if (fail_count == 0) begin
      $display("[forgiving_utf8_decoder] OK");
    end else begin
      $display("[forgiving_utf8_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[forgiving_utf8_decoder] ERROR");
    $finish;
  end

endmodule

[forgiving_utf8_decoder.f]
design/ufd_pkg.sv
design/ufd_front.sv
design/ufd_queue.sv
design/ufd_back.sv
design/forgiving_utf8_decoder.sv
tb/sv/forgiving_utf8_decoder_tb.sv
